@@ rtl/utfdec_pkg.sv @@
// Shared types and constants for the UTF-16 / UTF-32 stream decoder.
// No dependencies; imported by utf16_utf32_stream_decoder_top.
package utfdec_pkg;

    typedef enum logic [1:0] {
        MODE_UTF16_LE = 2'd0,
        MODE_UTF16_BE = 2'd1,
        MODE_UTF32_LE = 2'd2,
        MODE_UTF32_BE = 2'd3
    } encoding_mode_t;

    localparam logic [31:0] MAX_SCALAR   = 32'h0010_FFFF;
    localparam logic [31:0] SURR_FIRST   = 32'h0000_D800;
    localparam logic [31:0] SURR_LAST    = 32'h0000_DFFF;
    localparam logic [31:0] BMP_LAST     = 32'h0000_FFFF;
    localparam logic [31:0] PLANE1_FIRST = 32'h0001_0000;
    localparam logic [15:0] HIGH_FIRST   = 16'hD800;
    localparam logic [15:0] HIGH_LAST    = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST    = 16'hDC00;
    localparam logic [15:0] LOW_LAST     = 16'hDFFF;

    // result queue
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_error;
        logic        run_last;
    } result_t;

endpackage

@@ rtl/utf16_utf32_stream_decoder_top.sv @@
// Each accepted byte writes its results into the result queue registers, which drive the output.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_tready stays high; a byte that completes a surrogate pair gives two results,
// which the single output port drains from a four-entry result queue (input held
// while under two entries are free). Reset (rst_n low) clears mode to UTF-16 LE
// and all text state. Uses utfdec_pkg.
module utf16_utf32_stream_decoder_top
    import utfdec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // encoding_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] data_byte
    input  logic        s_tlast,        // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,        // [15:0] code_unit
    output logic        m_tuser,        // is_error
    output logic        m_tlast         // run_last
);

    encoding_mode_t mode_reg;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] asm_reg, asm_next;
    logic [15:0] pend_reg, pend_next;
    logic        have_pend_reg, have_pend_next;
    logic        err_latched_reg, err_latched_next;

    result_t              resq_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RESQ_AW:0]     count_reg;

    logic        in_fire, out_fire;
    logic        wide, little, complete, err;
    logic [31:0] base, asm_val, v32;
    logic [15:0] v16;
    logic [19:0] w;
    logic        v16_hi, v16_lo;
    logic [1:0]  n_push;
    result_t     res0, res1;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (count_reg <= (RESQ_AW+1)'(RESQ_DEPTH - 2));

    assign wide   = mode_reg[1];
    assign little = !mode_reg[0];

    always_comb
    begin
        base    = (pos_reg == 2'd0) ? 32'd0 : asm_reg;
        asm_val = little ? (base | ({24'd0, s_tdata} << {pos_reg, 3'b000}))
                         : {base[23:0], s_tdata};
        complete = wide ? (pos_reg == 2'd3) : (pos_reg != 2'd0);
        v32    = asm_val;
        v16    = asm_val[15:0];
        w      = 20'(v32 - PLANE1_FIRST);
        v16_hi = (v16 >= HIGH_FIRST) && (v16 <= HIGH_LAST);
        v16_lo = (v16 >= LOW_FIRST) && (v16 <= LOW_LAST);

        err            = 1'b0;
        n_push         = 2'd0;
        res0           = '0;
        res1           = '0;
        pos_next       = complete ? 2'd0 : 2'(pos_reg + 2'd1);
        asm_next       = asm_val;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;
        err_latched_next = err_latched_reg;

        if (complete)
        begin
            if (wide)
            begin
                if (have_pend_reg || v32 > MAX_SCALAR
                    || (v32 >= SURR_FIRST && v32 <= SURR_LAST))
                    err = 1'b1;
                else if (v32 <= BMP_LAST)
                begin
                    res0.code_unit = v32[15:0];
                    n_push = 2'd1;
                end
                else
                begin
                    res0.code_unit = HIGH_FIRST + {6'd0, w[19:10]};
                    res1.code_unit = LOW_FIRST + {6'd0, w[9:0]};
                    n_push = 2'd2;
                end
            end
            else if (have_pend_reg)
            begin
                if (v16_lo)
                begin
                    res0.code_unit = pend_reg;
                    res1.code_unit = v16;
                    n_push         = 2'd2;
                    have_pend_next = 1'b0;
                    pend_next      = '0;
                end
                else
                    err = 1'b1;
            end
            else if (v16_hi)
            begin
                pend_next      = v16;
                have_pend_next = 1'b1;
            end
            else if (v16_lo)
                err = 1'b1;
            else
            begin
                res0.code_unit = v16;
                n_push = 2'd1;
            end
        end

        // truncated unit or dangling high surrogate at end of text
        if (!err && s_tlast && (!complete || have_pend_next))
            err = 1'b1;

        if (err)
        begin
            res0   = '{code_unit: 16'd0, is_error: 1'b1, run_last: 1'b1};
            n_push = 2'd1;
            err_latched_next = !s_tlast;
            pos_next       = 2'd0;
            asm_next       = '0;
            pend_next      = '0;
            have_pend_next = 1'b0;
        end
        else
        begin
            if (n_push == 2'd1)
                res0.run_last = 1'b1;
            if (n_push == 2'd2)
                res1.run_last = 1'b1;
            if (s_tlast)
            begin
                pos_next       = 2'd0;
                asm_next       = '0;
                pend_next      = '0;
                have_pend_next = 1'b0;
            end
        end

        // drop bytes until end of text once an error has been reported
        if (err_latched_reg)
        begin
            n_push         = 2'd0;
            pos_next       = pos_reg;
            asm_next       = asm_reg;
            pend_next      = pend_reg;
            have_pend_next = have_pend_reg;
            err_latched_next = 1'b1;
            if (s_tlast)
            begin
                pos_next       = 2'd0;
                asm_next       = '0;
                pend_next      = '0;
                have_pend_next = 1'b0;
                err_latched_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_UTF16_LE;
            pos_reg         <= '0;
            asm_reg         <= '0;
            pend_reg        <= '0;
            have_pend_reg   <= 1'b0;
            err_latched_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= encoding_mode_t'(cfg_wdata);
            if (in_fire)
            begin
                pos_reg         <= pos_next;
                asm_reg         <= asm_next;
                pend_reg        <= pend_next;
                have_pend_reg   <= have_pend_next;
                err_latched_reg <= err_latched_next;
            end
        end
    end

    // result queue: up to two writes, one read per cycle
    logic [1:0] n_wr;
    assign n_wr = in_fire ? n_push : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= RESQ_AW'(wr_ptr_reg + RESQ_AW'(n_wr));
            if (out_fire)
                rd_ptr_reg <= RESQ_AW'(rd_ptr_reg + RESQ_AW'(1));
            count_reg <= (RESQ_AW+1)'(count_reg + (RESQ_AW+1)'(n_wr)
                                     - (RESQ_AW+1)'(out_fire));
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0)
            resq_reg[wr_ptr_reg] <= res0;
        if (n_wr == 2'd2)
            resq_reg[RESQ_AW'(wr_ptr_reg + RESQ_AW'(1))] <= res1;
    end

    result_t head;
    assign head     = resq_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.code_unit;
    assign m_tuser  = head.is_error;
    assign m_tlast  = head.run_last;

    // queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (RESQ_AW+1)'(RESQ_DEPTH))
        else $error("result queue overflow");

    // error results carry a zero unit and close the byte's results
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 16'd0 && m_tlast))
        else $error("malformed error result");

    // end of text leaves a clean decoder
    a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tlast) |=>
            (pos_reg == 2'd0 && !have_pend_reg && !err_latched_reg))
        else $error("state not cleared at end of text");

    // dropping bytes after an error gives no results
    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && err_latched_reg) |=> (count_reg <= $past(count_reg)))
        else $error("result produced while dropping");

endmodule
